[src/wof_pkg.sv]
// ============================================================================
// wof_pkg: shared types and constants of the winding order fixer
// Request and result layouts, opcode values, the internal command format
// between the front and back parts, and the depths of the internal queues.
// ============================================================================
package wof_pkg;

    // Fixed field widths of the requests and results
    localparam int COORD_BITS = 16;
    localparam int INDEX_BITS = 8;
    localparam int VERTEX_W   = 3 * COORD_BITS;

    // Internal queue depths
    localparam int CMDQ_DEPTH = 2;
    localparam int OUTQ_DEPTH = 8;
    localparam int OUTQ_CNT_W = $clog2(OUTQ_DEPTH + 1);

    // Request opcodes
    typedef logic [1:0] t_opcode;
    localparam t_opcode OP_CLEAR  = 2'd0;
    localparam t_opcode OP_VERTEX = 2'd1;
    localparam t_opcode OP_FACE   = 2'd2;

    // Work kinds handed from the front part to the back part
    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_VERTEX = 2'd1,
        CMD_FACE   = 2'd2
    } t_cmd_kind;

    typedef struct packed {
        t_opcode                       opcode;
        logic signed [COORD_BITS-1:0]  coord_x;
        logic signed [COORD_BITS-1:0]  coord_y;
        logic signed [COORD_BITS-1:0]  coord_z;
        logic [INDEX_BITS-1:0]         first_index;
        logic [INDEX_BITS-1:0]         second_index;
        logic [INDEX_BITS-1:0]         third_index;
    } t_in_item;

    typedef struct packed {
        logic [INDEX_BITS-1:0] out_first;
        logic [INDEX_BITS-1:0] out_second;
        logic [INDEX_BITS-1:0] out_third;
        logic                  was_swapped;
        logic                  index_error;
    } t_out_item;

    typedef struct packed {
        t_cmd_kind                     kind;
        logic                          face_err;
        logic signed [COORD_BITS-1:0]  coord_x;
        logic signed [COORD_BITS-1:0]  coord_y;
        logic signed [COORD_BITS-1:0]  coord_z;
        logic [INDEX_BITS-1:0]         idx_a;
        logic [INDEX_BITS-1:0]         idx_b;
        logic [INDEX_BITS-1:0]         idx_c;
    } t_cmd;

endpackage

[src/wof_ram.sv]
// ============================================================================
// wof_ram: generic single-port RAM
// One write or read address per cycle, registered read data.
// ============================================================================
module wof_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                         i_clk,
    input  logic                                         i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_addr,
    input  logic [WIDTH-1:0]                             i_wdata,
    output logic [WIDTH-1:0]                             o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write on request, read every cycle
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

[src/wof_fifo.sv]
// ============================================================================
// wof_fifo: small register queue
// Holds requests of any packed type; first-word-fall-through read side.
// ============================================================================
module wof_fifo #(
    parameter type t_data = logic,
    parameter int  DEPTH  = 2
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    input  t_data                        i_data,
    output logic                         o_full,
    input  logic                         i_pop,
    output t_data                        o_data,
    output logic                         o_empty,
    output logic [$clog2(DEPTH+1)-1:0]   o_count
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_data              r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;
    logic               do_push;
    logic               do_pop;

    function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] ptr);
        logic [PTR_W-1:0] nxt;
        if (ptr == PTR_W'(DEPTH - 1)) begin
            nxt = '0;
        end else begin
            nxt = ptr + 1'b1;
        end
        return nxt;
    endfunction

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_count = r_count;
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // Track occupancy
    always_comb begin
        unique case ({do_push, do_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    // Advance pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (do_push) begin
                r_wr_ptr <= next_ptr(r_wr_ptr);
            end
            if (do_pop) begin
                r_rd_ptr <= next_ptr(r_rd_ptr);
            end
        end
    end

    // Store payload
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

[src/wof_front.sv]
// ============================================================================
// wof_front: request intake and classification
// Decodes opcodes, drops unused opcodes and loads into a full store, and
// flags faces with an index at or past the current vertex count.
// ============================================================================
module wof_front
    import wof_pkg::*;
#(
    parameter int MAX_VERTICES = 256
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_accept,
    input  t_in_item i_item,
    output logic     o_cmd_valid,
    output t_cmd     o_cmd
);

    localparam int CNT_W = $clog2(MAX_VERTICES + 1);
    localparam int CMP_W = (CNT_W > INDEX_BITS) ? CNT_W : INDEX_BITS;

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             face_err;

    function automatic logic idx_bad(input logic [INDEX_BITS-1:0] idx,
                                     input logic [CNT_W-1:0]      cnt);
        return CMP_W'(idx) >= CMP_W'(cnt);
    endfunction

    assign face_err = idx_bad(i_item.first_index,  r_count) ||
                      idx_bad(i_item.second_index, r_count) ||
                      idx_bad(i_item.third_index,  r_count);

    // Classify the request and track the vertex count
    always_comb begin
        n_count        = r_count;
        o_cmd_valid    = 1'b0;
        o_cmd.kind     = CMD_CLEAR;
        o_cmd.face_err = face_err;
        o_cmd.coord_x  = i_item.coord_x;
        o_cmd.coord_y  = i_item.coord_y;
        o_cmd.coord_z  = i_item.coord_z;
        o_cmd.idx_a    = i_item.first_index;
        o_cmd.idx_b    = i_item.second_index;
        o_cmd.idx_c    = i_item.third_index;
        if (i_accept) begin
            unique case (i_item.opcode)
                OP_CLEAR: begin
                    o_cmd_valid = 1'b1;
                    o_cmd.kind  = CMD_CLEAR;
                    n_count     = '0;
                end
                OP_VERTEX: begin
                    if (r_count != CNT_W'(MAX_VERTICES)) begin
                        o_cmd_valid = 1'b1;
                        o_cmd.kind  = CMD_VERTEX;
                        n_count     = r_count + 1'b1;
                    end
                end
                OP_FACE: begin
                    o_cmd_valid = 1'b1;
                    o_cmd.kind  = CMD_FACE;
                end
                default: begin
                    // drop the unused opcode
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

endmodule

[src/wof_back.sv]
// ============================================================================
// wof_back: vertex store, running sums and face orientation pipeline
// Sequences store accesses (one write per vertex, three reads per face) and
// feeds a fixed-latency arithmetic pipeline that decides the index swap.
// ============================================================================
module wof_back
    import wof_pkg::*;
#(
    parameter int MAX_VERTICES = 256
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cmd_valid,
    input  t_cmd                  i_cmd,
    output logic                  o_cmd_pop,
    input  logic [OUTQ_CNT_W-1:0] i_out_count,
    output logic                  o_res_valid,
    output t_out_item             o_res
);

    localparam int CNT_W    = $clog2(MAX_VERTICES + 1);
    localparam int AW       = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int SUM_W    = COORD_BITS + CNT_W;
    localparam int T_W      = SUM_W + 1;
    localparam int D_W      = COORD_BITS + 1;
    localparam int CP_W     = 2 * D_W;
    localparam int N_W      = CP_W + 1;
    localparam int P_W      = N_W + T_W;
    localparam int DOT_W    = P_W + 2;
    localparam int CREDIT_W = OUTQ_CNT_W + 1;

    typedef enum logic [2:0] {
        ST_CMD = 3'b001,
        ST_RDB = 3'b010,
        ST_RDC = 3'b100
    } t_state;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic signed [COORD_BITS-1:0] z;
    } t_vertex;

    typedef struct packed {
        logic [INDEX_BITS-1:0] a;
        logic [INDEX_BITS-1:0] b;
        logic [INDEX_BITS-1:0] c;
        logic                  err;
    } t_tag;

    // Sequencer and store state
    t_state                   r_state;
    t_state                   n_state;
    logic [CNT_W-1:0]         r_count;
    logic signed [SUM_W-1:0]  r_sum_x;
    logic signed [SUM_W-1:0]  r_sum_y;
    logic signed [SUM_W-1:0]  r_sum_z;
    logic [OUTQ_CNT_W-1:0]    r_inflight;
    logic [CREDIT_W-1:0]      credit;
    logic                     credit_ok;
    logic                     face_start;
    logic                     do_clear;
    logic                     do_vertex;

    // Store port
    logic                     ram_we;
    logic [AW-1:0]            ram_addr;
    t_vertex                  ram_wdata;
    logic [VERTEX_W-1:0]      ram_rdata;
    t_vertex                  rd_vtx;

    // Read stages
    logic signed [CNT_W:0]    cnt_s;
    t_vertex                  r_a;
    logic signed [T_W-1:0]    na_x, na_y, na_z;
    logic signed [T_W-1:0]    r_na_x, r_na_y, r_na_z;
    logic signed [D_W-1:0]    u_x, u_y, u_z;
    logic signed [D_W-1:0]    r_u_x, r_u_y, r_u_z;
    logic signed [T_W-1:0]    t_x, t_y, t_z;
    logic signed [T_W-1:0]    r_t_x, r_t_y, r_t_z;
    t_tag                     r_tag;
    logic                     r_c_due;
    logic signed [D_W-1:0]    v_x, v_y, v_z;
    logic signed [D_W-1:0]    r_v_x, r_v_y, r_v_z;
    logic                     r_s1_valid;

    // Cross product stage
    logic signed [CP_W-1:0]   r_cp_yz, r_cp_zy, r_cp_zx, r_cp_xz, r_cp_xy, r_cp_yx;
    logic signed [CP_W-1:0]   cp_yz, cp_zy, cp_zx, cp_xz, cp_xy, cp_yx;
    logic signed [T_W-1:0]    r_s2_t_x, r_s2_t_y, r_s2_t_z;
    t_tag                     r_s2_tag;
    logic                     r_s2_valid;

    // Normal stage
    logic signed [N_W-1:0]    n_x, n_y, n_z;
    logic signed [N_W-1:0]    r_n_x, r_n_y, r_n_z;
    logic signed [T_W-1:0]    r_s3_t_x, r_s3_t_y, r_s3_t_z;
    t_tag                     r_s3_tag;
    logic                     r_s3_valid;

    // Dot product stage
    logic signed [P_W-1:0]    p_x, p_y, p_z;
    logic signed [P_W-1:0]    r_p_x, r_p_y, r_p_z;
    t_tag                     r_s4_tag;
    logic                     r_s4_valid;
    logic signed [DOT_W-1:0]  dot;
    logic                     swap;

    function automatic logic [AW-1:0] to_addr(input logic [INDEX_BITS-1:0] idx);
        logic [AW+INDEX_BITS-1:0] wide;
        wide = {{AW{1'b0}}, idx};
        return wide[AW-1:0];
    endfunction

    wof_ram #(
        .WIDTH (VERTEX_W),
        .DEPTH (MAX_VERTICES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    assign rd_vtx = ram_rdata;

    // Start a face only when its result has a reserved slot downstream
    assign credit    = CREDIT_W'(r_inflight) + CREDIT_W'(i_out_count);
    assign credit_ok = (credit < CREDIT_W'(OUTQ_DEPTH));

    // Sequence store accesses
    always_comb begin
        n_state     = r_state;
        o_cmd_pop   = 1'b0;
        ram_we      = 1'b0;
        ram_addr    = to_addr(i_cmd.idx_a);
        ram_wdata.x = i_cmd.coord_x;
        ram_wdata.y = i_cmd.coord_y;
        ram_wdata.z = i_cmd.coord_z;
        face_start  = 1'b0;
        do_clear    = 1'b0;
        do_vertex   = 1'b0;
        unique case (r_state)
            ST_CMD: begin
                if (i_cmd_valid) begin
                    unique case (i_cmd.kind)
                        CMD_CLEAR: begin
                            o_cmd_pop = 1'b1;
                            do_clear  = 1'b1;
                        end
                        CMD_VERTEX: begin
                            o_cmd_pop = 1'b1;
                            do_vertex = 1'b1;
                            ram_we    = 1'b1;
                            ram_addr  = r_count[AW-1:0];
                        end
                        CMD_FACE: begin
                            if (credit_ok) begin
                                face_start = 1'b1;
                                n_state    = ST_RDB;
                            end
                        end
                        default: begin
                            o_cmd_pop = 1'b1;
                        end
                    endcase
                end
            end
            ST_RDB: begin
                ram_addr = to_addr(i_cmd.idx_b);
                n_state  = ST_RDC;
            end
            ST_RDC: begin
                ram_addr  = to_addr(i_cmd.idx_c);
                o_cmd_pop = 1'b1;
                n_state   = ST_CMD;
            end
            default: begin
                n_state = ST_CMD;
            end
        endcase
    end

    // Control state, count and running sums
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CMD;
            r_count    <= '0;
            r_sum_x    <= '0;
            r_sum_y    <= '0;
            r_sum_z    <= '0;
            r_inflight <= '0;
            r_c_due    <= 1'b0;
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_c_due    <= (r_state == ST_RDC);
            r_s1_valid <= r_c_due;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
            r_s4_valid <= r_s3_valid;
            if (do_clear) begin
                r_count <= '0;
                r_sum_x <= '0;
                r_sum_y <= '0;
                r_sum_z <= '0;
            end else if (do_vertex) begin
                r_count <= r_count + 1'b1;
                r_sum_x <= r_sum_x + SUM_W'(i_cmd.coord_x);
                r_sum_y <= r_sum_y + SUM_W'(i_cmd.coord_y);
                r_sum_z <= r_sum_z + SUM_W'(i_cmd.coord_z);
            end
            unique case ({face_start, r_s4_valid})
                2'b10:   r_inflight <= r_inflight + 1'b1;
                2'b01:   r_inflight <= r_inflight - 1'b1;
                default: r_inflight <= r_inflight;
            endcase
        end
    end

    // Stage arithmetic
    assign cnt_s = {1'b0, r_count};
    assign na_x  = T_W'(cnt_s) * T_W'(rd_vtx.x);
    assign na_y  = T_W'(cnt_s) * T_W'(rd_vtx.y);
    assign na_z  = T_W'(cnt_s) * T_W'(rd_vtx.z);
    assign u_x   = D_W'(rd_vtx.x) - D_W'(r_a.x);
    assign u_y   = D_W'(rd_vtx.y) - D_W'(r_a.y);
    assign u_z   = D_W'(rd_vtx.z) - D_W'(r_a.z);
    assign t_x   = T_W'(r_sum_x) - r_na_x;
    assign t_y   = T_W'(r_sum_y) - r_na_y;
    assign t_z   = T_W'(r_sum_z) - r_na_z;
    assign v_x   = D_W'(rd_vtx.x) - D_W'(r_a.x);
    assign v_y   = D_W'(rd_vtx.y) - D_W'(r_a.y);
    assign v_z   = D_W'(rd_vtx.z) - D_W'(r_a.z);
    assign cp_yz = CP_W'(r_u_y) * CP_W'(r_v_z);
    assign cp_zy = CP_W'(r_u_z) * CP_W'(r_v_y);
    assign cp_zx = CP_W'(r_u_z) * CP_W'(r_v_x);
    assign cp_xz = CP_W'(r_u_x) * CP_W'(r_v_z);
    assign cp_xy = CP_W'(r_u_x) * CP_W'(r_v_y);
    assign cp_yx = CP_W'(r_u_y) * CP_W'(r_v_x);
    assign n_x   = N_W'(r_cp_yz) - N_W'(r_cp_zy);
    assign n_y   = N_W'(r_cp_zx) - N_W'(r_cp_xz);
    assign n_z   = N_W'(r_cp_xy) - N_W'(r_cp_yx);
    assign p_x   = P_W'(r_n_x) * P_W'(r_s3_t_x);
    assign p_y   = P_W'(r_n_y) * P_W'(r_s3_t_y);
    assign p_z   = P_W'(r_n_z) * P_W'(r_s3_t_z);

    // Advance the face pipeline
    always_ff @(posedge i_clk) begin
        // vertex a arrives: keep it and form count * a
        if (r_state == ST_RDB) begin
            r_a    <= rd_vtx;
            r_na_x <= na_x;
            r_na_y <= na_y;
            r_na_z <= na_z;
        end
        // vertex b arrives: edge b - a, centroid offset, face indices
        if (r_state == ST_RDC) begin
            r_u_x     <= u_x;
            r_u_y     <= u_y;
            r_u_z     <= u_z;
            r_t_x     <= t_x;
            r_t_y     <= t_y;
            r_t_z     <= t_z;
            r_tag.a   <= i_cmd.idx_a;
            r_tag.b   <= i_cmd.idx_b;
            r_tag.c   <= i_cmd.idx_c;
            r_tag.err <= i_cmd.face_err;
        end
        // vertex c arrives: edge c - a
        if (r_c_due) begin
            r_v_x <= v_x;
            r_v_y <= v_y;
            r_v_z <= v_z;
        end
        if (r_s1_valid) begin
            r_cp_yz  <= cp_yz;
            r_cp_zy  <= cp_zy;
            r_cp_zx  <= cp_zx;
            r_cp_xz  <= cp_xz;
            r_cp_xy  <= cp_xy;
            r_cp_yx  <= cp_yx;
            r_s2_t_x <= r_t_x;
            r_s2_t_y <= r_t_y;
            r_s2_t_z <= r_t_z;
            r_s2_tag <= r_tag;
        end
        if (r_s2_valid) begin
            r_n_x    <= n_x;
            r_n_y    <= n_y;
            r_n_z    <= n_z;
            r_s3_t_x <= r_s2_t_x;
            r_s3_t_y <= r_s2_t_y;
            r_s3_t_z <= r_s2_t_z;
            r_s3_tag <= r_s2_tag;
        end
        if (r_s3_valid) begin
            r_p_x    <= p_x;
            r_p_y    <= p_y;
            r_p_z    <= p_z;
            r_s4_tag <= r_s3_tag;
        end
    end

    // Swap when the normal points toward the centroid
    assign dot  = DOT_W'(r_p_x) + DOT_W'(r_p_y) + DOT_W'(r_p_z);
    assign swap = !r_s4_tag.err && !dot[DOT_W-1] && (dot != '0);

    assign o_res_valid       = r_s4_valid;
    assign o_res.out_first   = r_s4_tag.a;
    assign o_res.out_second  = swap ? r_s4_tag.c : r_s4_tag.b;
    assign o_res.out_third   = swap ? r_s4_tag.b : r_s4_tag.c;
    assign o_res.was_swapped = swap;
    assign o_res.index_error = r_s4_tag.err;

endmodule

[src/winding_order_fixer_unit.sv]
// ============================================================================
// winding_order_fixer_unit: triangle winding correction against the centroid
// Loads vertices, keeps running coordinate sums, and reorders face indices so
// that each face normal points away from the mesh centroid.
// ============================================================================
// A clear or a vertex load is done in the command state; a face holds the
// back end through ST_CMD, ST_RDB and ST_RDC, one per vertex read from the
// single-port vertex store, then passes the cross product, normal and dot
// product stages to the output queue. The front end takes a request every
// cycle while the 2-entry command queue has room, and the 8-entry result
// queue lets results wait while new requests keep flowing. The vertex store
// is not cleared at reset or by a clear request; only entries loaded since
// the last clear affect a result, so no clearing pass is needed. Loads beyond
// MAX_VERTICES are ignored, opcode 3 is ignored, and a face with an index at
// or past the vertex count comes back unchanged with index_error set.
module winding_order_fixer_unit
    import wof_pkg::*;
#(
    parameter int MAX_VERTICES = 256
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      push,
    output logic      full,
    input  t_in_item  i_item,
    output logic      empty,
    input  logic      pop,
    output t_out_item o_item
);

    logic                  in_accept;
    logic                  front_valid;
    t_cmd                  front_cmd;
    t_cmd                  cmd_head;
    logic                  cmd_empty;
    logic                  cmd_pop;
    logic                  res_valid;
    t_out_item             res;
    logic [OUTQ_CNT_W-1:0] out_count;

    assign in_accept = push && !full;

    // Accept and classify requests
    wof_front #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (in_accept),
        .i_item      (i_item),
        .o_cmd_valid (front_valid),
        .o_cmd       (front_cmd)
    );

    // Decouple front and back
    wof_fifo #(
        .t_data (t_cmd),
        .DEPTH  (CMDQ_DEPTH)
    ) u_cmd_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_valid),
        .i_data  (front_cmd),
        .o_full  (full),
        .i_pop   (cmd_pop),
        .o_data  (cmd_head),
        .o_empty (cmd_empty),
        .o_count ()
    );

    // Execute store accesses and face arithmetic
    wof_back #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (!cmd_empty),
        .i_cmd       (cmd_head),
        .o_cmd_pop   (cmd_pop),
        .i_out_count (out_count),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // Hold results until popped
    wof_fifo #(
        .t_data (t_out_item),
        .DEPTH  (OUTQ_DEPTH)
    ) u_out_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_valid),
        .i_data  (res),
        .o_full  (),
        .i_pop   (pop),
        .o_data  (o_item),
        .o_empty (empty),
        .o_count (out_count)
    );

endmodule

[src/wof_checker.sv]
// ============================================================================
// wof_checker: port-level checks of the winding order fixer
// Watches the result side over time and is bound to the top level.
// ============================================================================
module wof_checker
    import wof_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      empty,
    input logic      pop,
    input t_out_item o_item
);

    // Reset leaves no result waiting
    a_empty_after_reset: assert property (
        @(posedge i_clk) !i_rst_n |=> empty
    ) else $error("result queue not empty after reset");

    // A waiting result holds while not popped
    a_hold_when_stalled: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_item))
    ) else $error("waiting result changed before pop");

    // A face with a bad index is never reordered
    a_no_swap_on_error: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> !(o_item.was_swapped && o_item.index_error)
    ) else $error("swap reported on a face with an index error");

    // A reordered face has a nonzero normal, so its indices are distinct
    a_swap_distinct: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_item.was_swapped) |->
            (o_item.out_first != o_item.out_second &&
             o_item.out_first != o_item.out_third &&
             o_item.out_second != o_item.out_third)
    ) else $error("swap reported on a degenerate face");

endmodule

bind winding_order_fixer_unit wof_checker u_wof_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .empty   (empty),
    .pop     (pop),
    .o_item  (o_item)
);

[bench/tb.sv]
// ============================================================================
// tb: self-checking bench for winding_order_fixer_unit
// Sends clear, vertex-load and face requests through the push/full side,
// predicts each face result from its own copy of the mesh (stored vertices,
// coordinate sums, vertex count) and checks what comes out of the empty/pop
// side, in order, field by field. Both sides pause at random.
// ============================================================================
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import wof_pkg::*;

    localparam int      MESH_CAPACITY = 256;
    localparam int      RANDOM_ITEMS  = 600;
    localparam t_opcode OP_UNUSED     = 2'd3;

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic [INDEX_BITS-1:0]        t_index;

    // Mesh model and the queue of face results still to come
    class winding_scoreboard;
        longint      mesh_x[MESH_CAPACITY];
        longint      mesh_y[MESH_CAPACITY];
        longint      mesh_z[MESH_CAPACITY];
        int unsigned mesh_count;
        longint      sum_x, sum_y, sum_z;
        t_out_item   expected_faces[$];
        int unsigned fail_count;

        function new();
            mesh_count = 0;
            sum_x      = 0;
            sum_y      = 0;
            sum_z      = 0;
            fail_count = 0;
        endfunction

        // Append one face result behind those already waiting
        function void enqueue_face(t_out_item res);
            expected_faces = {expected_faces, res};
        endfunction

        // Advance the mesh by one accepted request; queue a face result
        function void note_request(t_in_item req);
            longint      ux, uy, uz, wx, wy, wz;
            longint      nx, ny, nz, tx, ty, tz, cnt, dot;
            int unsigned ia, ib, ic;
            bit          bad, swap;
            t_out_item   res;
            case (req.opcode)
                OP_CLEAR: begin
                    mesh_count = 0;
                    sum_x      = 0;
                    sum_y      = 0;
                    sum_z      = 0;
                end
                OP_VERTEX: begin
                    if (mesh_count < MESH_CAPACITY) begin
                        mesh_x[mesh_count] = longint'($signed(req.coord_x));
                        mesh_y[mesh_count] = longint'($signed(req.coord_y));
                        mesh_z[mesh_count] = longint'($signed(req.coord_z));
                        sum_x += mesh_x[mesh_count];
                        sum_y += mesh_y[mesh_count];
                        sum_z += mesh_z[mesh_count];
                        mesh_count++;
                    end
                end
                OP_FACE: begin
                    ia   = req.first_index;
                    ib   = req.second_index;
                    ic   = req.third_index;
                    bad  = (ia >= mesh_count) || (ib >= mesh_count) || (ic >= mesh_count);
                    swap = 1'b0;
                    if (!bad) begin
                        // normal of the face and count times (centroid - a)
                        ux  = mesh_x[ib] - mesh_x[ia];
                        uy  = mesh_y[ib] - mesh_y[ia];
                        uz  = mesh_z[ib] - mesh_z[ia];
                        wx  = mesh_x[ic] - mesh_x[ia];
                        wy  = mesh_y[ic] - mesh_y[ia];
                        wz  = mesh_z[ic] - mesh_z[ia];
                        nx  = uy * wz - uz * wy;
                        ny  = uz * wx - ux * wz;
                        nz  = ux * wy - uy * wx;
                        cnt = longint'(mesh_count);
                        tx  = sum_x - cnt * mesh_x[ia];
                        ty  = sum_y - cnt * mesh_y[ia];
                        tz  = sum_z - cnt * mesh_z[ia];
                        dot = nx * tx + ny * ty + nz * tz;
                        swap = (dot > 0);
                    end
                    res.out_first   = t_index'(ia);
                    res.out_second  = swap ? t_index'(ic) : t_index'(ib);
                    res.out_third   = swap ? t_index'(ib) : t_index'(ic);
                    res.was_swapped = swap;
                    res.index_error = bad;
                    enqueue_face(res);
                end
                default: ;
            endcase
        endfunction

        // Compare one popped result with the oldest expected face
        function void check_result(t_out_item got);
            t_out_item want;
            if (expected_faces.size() == 0) begin
                $error("unexpected result: first %0d second %0d third %0d",
                       got.out_first, got.out_second, got.out_third);
                fail_count++;
                return;
            end
            want = expected_faces.pop_front();
            if (got.out_first !== want.out_first) begin
                $error("out_first: expected %0d, actual %0d", want.out_first, got.out_first);
                fail_count++;
            end
            if (got.out_second !== want.out_second) begin
                $error("out_second: expected %0d, actual %0d",
                       want.out_second, got.out_second);
                fail_count++;
            end
            if (got.out_third !== want.out_third) begin
                $error("out_third: expected %0d, actual %0d", want.out_third, got.out_third);
                fail_count++;
            end
            if (got.was_swapped !== want.was_swapped) begin
                $error("was_swapped: expected %0d, actual %0d",
                       want.was_swapped, got.was_swapped);
                fail_count++;
            end
            if (got.index_error !== want.index_error) begin
                $error("index_error: expected %0d, actual %0d",
                       want.index_error, got.index_error);
                fail_count++;
            end
        endfunction

        function int unsigned faces_waiting();
            return expected_faces.size();
        endfunction
    endclass

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      push    = 1'b0;
    logic      pop     = 1'b0;
    t_in_item  i_item  = '0;
    logic      full;
    logic      empty;
    t_out_item o_item;

    winding_scoreboard mesh_sb = new();
    int unsigned       sent_count = 0;
    bit                send_calm  = 1'b0;
    bit                take_calm  = 1'b0;

    winding_order_fixer_unit #(
        .MAX_VERTICES(MESH_CAPACITY)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .push   (push),
        .full   (full),
        .i_item (i_item),
        .empty  (empty),
        .pop    (pop),
        .o_item (o_item)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Mostly short gaps, a few long ones, none at all while calm
    function automatic int pick_gap(input bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    function automatic t_coord rand_coord(input int mode);
        int unsigned pick;
        case (mode)
            0: return t_coord'($urandom);
            1: return t_coord'($urandom_range(0, 1023)) - t_coord'(512);
            default: begin
                pick = $urandom_range(0, 4);
                case (pick)
                    0: return t_coord'(-32768);
                    1: return t_coord'(32767);
                    2: return t_coord'(-1);
                    3: return t_coord'(1);
                    default: return t_coord'(0);
                endcase
            end
        endcase
    endfunction

    function automatic t_index rand_index(input int unsigned cnt);
        return t_index'($urandom_range(0, cnt - 1));
    endfunction

    // Fill every field with noise; builders then set what matters
    function automatic t_in_item noise_request();
        t_in_item r;
        r.opcode       = t_opcode'($urandom);
        r.coord_x      = t_coord'($urandom);
        r.coord_y      = t_coord'($urandom);
        r.coord_z      = t_coord'($urandom);
        r.first_index  = t_index'($urandom);
        r.second_index = t_index'($urandom);
        r.third_index  = t_index'($urandom);
        return r;
    endfunction

    function automatic t_in_item clear_request();
        t_in_item r;
        r        = noise_request();
        r.opcode = OP_CLEAR;
        return r;
    endfunction

    function automatic t_in_item unused_request();
        t_in_item r;
        r        = noise_request();
        r.opcode = OP_UNUSED;
        return r;
    endfunction

    function automatic t_in_item vertex_request(input t_coord x, input t_coord y,
                                                input t_coord z);
        t_in_item r;
        r         = noise_request();
        r.opcode  = OP_VERTEX;
        r.coord_x = x;
        r.coord_y = y;
        r.coord_z = z;
        return r;
    endfunction

    function automatic t_in_item face_request(input t_index a, input t_index b,
                                              input t_index c);
        t_in_item r;
        r              = noise_request();
        r.opcode       = OP_FACE;
        r.first_index  = a;
        r.second_index = b;
        r.third_index  = c;
        return r;
    endfunction

    // Hold push until the request is taken, then note it
    task automatic send_request(input t_in_item req);
        int gap;
        gap = pick_gap(send_calm);
        if ($urandom_range(0, 63) == 0) send_calm = !send_calm;
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push   <= 1'b1;
        i_item <= req;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        mesh_sb.note_request(req);
        if (req.opcode != OP_UNUSED) sent_count++;
    endtask

    task automatic send_vertex(input int mode);
        send_request(vertex_request(rand_coord(mode), rand_coord(mode), rand_coord(mode)));
    endtask

    // One mesh: maybe clear, load vertices, then a run of faces and noise
    task automatic send_mesh(input bit fill_up);
        int          mode;
        int unsigned n_load, n_face, pick, cnt;
        t_index      a;
        mode = $urandom_range(0, 2);
        if ($urandom_range(0, 7) != 0) send_request(clear_request());
        if (fill_up) begin
            while (mesh_sb.mesh_count < MESH_CAPACITY) send_vertex(mode);
            repeat (2) send_vertex(0);
            send_request(face_request(8'd255, 8'd0, 8'd128));
        end else begin
            n_load = $urandom_range(1, 12);
            repeat (n_load) send_vertex(mode);
        end
        n_face = $urandom_range(2, 10);
        repeat (n_face) begin
            pick = $urandom_range(0, 19);
            cnt  = mesh_sb.mesh_count;
            if (pick == 0) begin
                send_request(unused_request());
            end else if (pick == 1) begin
                send_vertex(mode);
            end else if (pick < 5 || cnt == 0) begin
                send_request(face_request(t_index'($urandom), t_index'($urandom),
                                          t_index'($urandom)));
            end else if (pick == 5) begin
                a = rand_index(cnt);
                send_request(face_request(a, a, rand_index(cnt)));
            end else begin
                send_request(face_request(rand_index(cnt), rand_index(cnt),
                                          rand_index(cnt)));
            end
        end
    endtask

    // Drain results, pausing pop at random
    initial begin
        int gap;
        wait (i_rst_n);
        forever begin
            gap = pick_gap(take_calm);
            if ($urandom_range(0, 63) == 0) take_calm = !take_calm;
            if (gap > 0) begin
                pop <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            pop <= 1'b1;
            @(posedge i_clk);
            while (empty) @(posedge i_clk);
            mesh_sb.check_result(o_item);
        end
    end

    // Reset, directed requests, random meshes, drain
    initial begin
        bit filled;
        filled = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // face on an empty mesh, unused opcode
        send_request(face_request(8'd0, 8'd1, 8'd2));
        send_request(unused_request());
        // tetrahedron at the coordinate extremes
        send_request(vertex_request(-16'sd32768, -16'sd32768, -16'sd32768));
        send_request(vertex_request(16'sd32767, -16'sd32768, -16'sd32768));
        send_request(vertex_request(-16'sd32768, 16'sd32767, -16'sd32768));
        send_request(vertex_request(-16'sd32768, -16'sd32768, 16'sd32767));
        send_request(face_request(8'd0, 8'd1, 8'd2));
        send_request(face_request(8'd0, 8'd2, 8'd1));
        send_request(face_request(8'd1, 8'd2, 8'd3));
        send_request(face_request(8'd1, 8'd3, 8'd2));
        // index at the count, index at the top of its range
        send_request(face_request(8'd0, 8'd1, 8'd4));
        send_request(face_request(8'd255, 8'd0, 8'd1));
        // repeated indices give a zero normal
        send_request(face_request(8'd1, 8'd1, 8'd2));
        send_request(face_request(8'd3, 8'd3, 8'd3));
        // clear drops the mesh, old entries become out of range
        send_request(clear_request());
        send_request(face_request(8'd0, 8'd1, 8'd2));
        // flat mesh: centroid in the face plane
        send_request(vertex_request(16'sd0, 16'sd0, 16'sd0));
        send_request(vertex_request(16'sd256, 16'sd0, 16'sd0));
        send_request(vertex_request(16'sd0, 16'sd256, 16'sd0));
        send_request(face_request(8'd0, 8'd1, 8'd2));
        send_request(face_request(8'd2, 8'd1, 8'd0));
        // lift the centroid off the plane
        send_request(vertex_request(16'sd1, 16'sd1, -16'sd1));
        send_request(face_request(8'd0, 8'd1, 8'd2));
        send_request(face_request(8'd0, 8'd2, 8'd1));

        sent_count = 0;
        while (sent_count < RANDOM_ITEMS) begin
            if (!filled && sent_count > RANDOM_ITEMS / 2) begin
                filled = 1'b1;
                send_mesh(1'b1);
            end else begin
                send_mesh(1'b0);
            end
        end
        push <= 1'b0;

        while (mesh_sb.faces_waiting() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (mesh_sb.fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // Stop a hung run
    initial begin
        #10_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
